/* rtl/core/tmbcr_pkg.sv */
package tmbcr_pkg;

	localparam int CoordW = 16;
	localparam int SizeW  = 12;
	localparam int MoveW  = 13;
	localparam int CfgW   = 7;

	// fraction bits of every coordinate
	localparam int FracBits = 4;

	localparam logic [1:0] CfgTileSize = 2'd0;
	localparam logic [1:0] CfgMapCols  = 2'd1;
	localparam logic [1:0] CfgMapRows  = 2'd2;

	localparam logic CmdWrite = 1'b0;
	localparam logic CmdMove  = 1'b1;

	// request to the shared divider
	typedef struct packed {
		logic              start;
		logic [16:0]       dividend;
	} div_req_t;

	// answer of the shared divider
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [16:0]       quotient;
	} div_rsp_t;

endpackage

/* rtl/core/tmbcr_ram.sv */
module tmbcr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/tmbcr_div.sv */
module tmbcr_div #(
	parameter int SPAN_W = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmbcr_pkg::div_req_t   req,
	input  logic [SPAN_W-1:0]     divisor,
	output tmbcr_pkg::div_rsp_t   rsp
);

	localparam int NW = 17;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]     num_q;
	logic [SPAN_W:0]   rem_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SPAN_W:0]   trial;
	logic [SPAN_W+1:0] diff;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q[SPAN_W-1:0], num_q[NW-1]};
		diff  = {1'b0, trial} - {2'b00, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[SPAN_W+1]) begin
				rem_q <= diff[SPAN_W:0];
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

/* rtl/core/tile_map_box_collision_resolve.sv */
// Tile map box collision resolver, axis separated (X phase, then Y phase).
// Tile write: written to the map in the cycle it is taken; writes can follow back to back.
// Move: per axis, apply the move, four serial divisions for the covered tile range, a setup
// step, a check of every covered tile, then a walk of the leading-line tiles on a hit. One
// move at a time; the next is taken after its result is taken.
// Reset (arst_n low): registers to defaults, then a clearing pass zeroes every map entry.
module tile_map_box_collision_resolve #(
	parameter int MAP_COLS      = 64,
	parameter int MAP_ROWS      = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command, tile_col, tile_row, tile_solid, box_left, box_top, box_width,
	// box_height, move_x, move_y (lowest bit first), 96 bits
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// new_left, new_top
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int DEPTH  = MAP_COLS * MAP_ROWS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SPAN_W = 7 + tmbcr_pkg::FracBits;
	localparam int TW     = 17;

	localparam logic [3:0] StIdle  = 4'd0;
	localparam logic [3:0] StClr   = 4'd1;
	localparam logic [3:0] StDiv   = 4'd2;
	localparam logic [3:0] StDivW  = 4'd3;
	localparam logic [3:0] StScan  = 4'd4;
	localparam logic [3:0] StRd    = 4'd5;
	localparam logic [3:0] StChk   = 4'd6;
	localparam logic [3:0] StLead  = 4'd7;
	localparam logic [3:0] StLRd   = 4'd8;
	localparam logic [3:0] StLChk  = 4'd9;
	localparam logic [3:0] StNext  = 4'd10;
	localparam logic [3:0] StOut   = 4'd11;

	logic [3:0]  st_q;
	logic        axis_q;      // 0 = X phase, 1 = Y phase
	logic [1:0]  dsel_q;      // which division
	logic [AW-1:0] clr_q;
	logic [6:0]  tsize_q, cols_q, rows_q;
	logic [16:0] x_q, y_q;
	logic [11:0] w_q, h_q;
	logic signed [12:0] dx_q, dy_q;
	logic [TW-1:0] tx0_q, tx1_q, ty0_q, ty1_q;
	logic [TW-1:0] ci_q, ri_q;
	logic [TW-1:0] lead_q, k_q;
	logic        oob_q;

	tmbcr_pkg::div_req_t dreq;
	tmbcr_pkg::div_rsp_t drsp;
	logic [SPAN_W-1:0] span;
	logic        ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic        ram_wd, ram_rd;
	logic [8:0]  ecols, erows;
	logic        s_acc;

	assign span = {tsize_q, {tmbcr_pkg::FracBits{1'b0}}};
	assign ecols = ({2'b00, cols_q} > 9'(MAP_COLS)) ? 9'(MAP_COLS) : {2'b00, cols_q};
	assign erows = ({2'b00, rows_q} > 9'(MAP_ROWS)) ? 9'(MAP_ROWS) : {2'b00, rows_q};

	assign s_tready  = (st_q == StIdle);
	assign cfg_ready = 1'b1;
	assign s_acc     = s_tvalid && s_tready;
	assign m_tvalid  = (st_q == StOut);
	assign m_tdata   = {y_q[15:0], x_q[15:0]};

	// division operands: first/last tile of x and y extents
	logic [16:0] x_end, y_end;
	always_comb begin
		x_end = x_q + {5'd0, w_q};
		y_end = y_q + {5'd0, h_q};
		dreq.start = (st_q == StDiv);
		unique case (dsel_q)
			2'd0: dreq.dividend = x_q;
			2'd1: dreq.dividend = (x_end == 0) ? 17'd0 : x_end - 1'b1;
			2'd2: dreq.dividend = y_q;
			default: dreq.dividend = (y_end == 0) ? 17'd0 : y_end - 1'b1;
		endcase
	end

	tmbcr_div #(.SPAN_W(SPAN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .divisor(span), .rsp(drsp)
	);

	// map address for a tile (col, row)
	logic [TW-1:0] qc, qr;
	always_comb begin
		qc = ci_q;
		qr = ri_q;
		if (st_q == StLead || st_q == StLRd || st_q == StLChk) begin
			qc = axis_q ? k_q : lead_q;
			qr = axis_q ? lead_q : k_q;
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = clr_q;
		ram_wd = 1'b0;
		if (st_q == StClr) begin
			ram_we = 1'b1;
		end else if (s_acc && s_tdata[0] == tmbcr_pkg::CmdWrite) begin
			ram_we = (32'(s_tdata[6:1]) < MAP_COLS) && (32'(s_tdata[12:7]) < MAP_ROWS);
			ram_wa = AW'(32'(s_tdata[12:7]) * MAP_COLS + 32'(s_tdata[6:1]));
			ram_wd = s_tdata[13];
		end
		ram_ra = AW'(32'(qr[7:0]) * MAP_COLS + 32'(qc[7:0]));
	end

	tmbcr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic solid_now;
	assign solid_now = oob_q || ram_rd;

	// saturating helper
	function automatic logic [16:0] sat(input logic signed [19:0] v);
		if (v < 0) return 17'd0;
		if (v > 20'sd65535) return 17'd65535;
		return v[16:0];
	endfunction

	logic signed [19:0] mv;
	logic signed [19:0] snap;
	logic signed [12:0] dcur;
	logic [11:0] lcur;
	always_comb begin
		dcur = axis_q ? dy_q : dx_q;
		lcur = axis_q ? h_q : w_q;
		if (dcur > 0) snap = $signed({3'd0, lead_q[16:0]} * {9'd0, span}) -
			$signed({8'd0, lcur});
		else snap = $signed({3'd0, (lead_q[16:0] + 1'b1)} * {9'd0, span});
		mv = axis_q ? $signed({3'd0, y_q}) + 20'(dy_q) : $signed({3'd0, x_q}) + 20'(dx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= StClr;
			clr_q   <= '0;
			tsize_q <= 7'd16;
			cols_q  <= 7'd64;
			rows_q  <= 7'd64;
			axis_q  <= 1'b0;
			dsel_q  <= '0;
			tx0_q   <= '0;
			tx1_q   <= '0;
			ty0_q   <= '0;
			ty1_q   <= '0;
			ci_q    <= '0;
			ri_q    <= '0;
			lead_q  <= '0;
			k_q     <= '0;
			oob_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					tmbcr_pkg::CfgTileSize: tsize_q <= cfg_data;
					tmbcr_pkg::CfgMapCols:  cols_q  <= cfg_data;
					tmbcr_pkg::CfgMapRows:  rows_q  <= cfg_data;
					default: ;
				endcase
			end
			unique case (st_q)
				StClr: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == DEPTH - 1) st_q <= StIdle;
				end
				StIdle: if (s_acc && s_tdata[0] == tmbcr_pkg::CmdMove) begin
					axis_q <= 1'b0;
					st_q   <= StNext;
				end
				StNext: begin
					// apply move on current axis (on both axes when the tile size is zero)
					dsel_q <= '0;
					st_q   <= (tsize_q == 0) ? StOut : StDiv;
				end
				StDiv: st_q <= StDivW;
				StDivW: if (drsp.done) begin
					unique case (dsel_q)
						2'd0: tx0_q <= drsp.quotient;
						2'd1: tx1_q <= drsp.quotient;
						2'd2: ty0_q <= drsp.quotient;
						default: ty1_q <= drsp.quotient;
					endcase
					dsel_q <= dsel_q + 1'b1;
					st_q   <= (dsel_q == 2'd3) ? StScan : StDiv;
				end
				StScan: begin
					ci_q <= tx0_q;
					ri_q <= ty0_q;
					if (tx1_q < tx0_q || ty1_q < ty0_q) st_q <= axis_q ? StOut : StNext;
					else st_q <= StRd;
					if (tx1_q < tx0_q || ty1_q < ty0_q) axis_q <= 1'b1;
				end
				StRd: begin
					oob_q <= (ci_q >= TW'(ecols)) || (ri_q >= TW'(erows));
					st_q  <= StChk;
				end
				StChk: begin
					if (solid_now) begin
						if (dcur == 0) begin
							st_q <= axis_q ? StOut : StNext;
							axis_q <= 1'b1;
						end else begin
							k_q    <= axis_q ? tx0_q : ty0_q;
							lead_q <= axis_q ? ((dy_q > 0) ? ty1_q : ty0_q)
							                 : ((dx_q > 0) ? tx1_q : tx0_q);
							st_q   <= StLead;
						end
					end else if (ci_q == tx1_q) begin
						ci_q <= tx0_q;
						if (ri_q == ty1_q) begin
							st_q <= axis_q ? StOut : StNext;
							axis_q <= 1'b1;
						end else begin
							ri_q <= ri_q + 1'b1;
							st_q <= StRd;
						end
					end else begin
						ci_q <= ci_q + 1'b1;
						st_q <= StRd;
					end
				end
				StLead: st_q <= StLRd;
				StLRd: begin
					oob_q <= (qc >= TW'(ecols)) || (qr >= TW'(erows));
					st_q  <= StLChk;
				end
				StLChk: begin
					if (solid_now || k_q == (axis_q ? tx1_q : ty1_q)) begin
						st_q <= axis_q ? StOut : StNext;
						axis_q <= 1'b1;
					end else begin
						k_q  <= k_q + 1'b1;
						st_q <= StLead;
					end
				end
				StOut: if (m_tready) st_q <= StIdle;
				default: st_q <= StIdle;
			endcase
		end
	end

	// input capture, moved position at the start of each axis phase, snap on a hit
	always_ff @(posedge clk) begin
		if (s_acc) begin
			x_q  <= {1'b0, s_tdata[29:14]};
			y_q  <= {1'b0, s_tdata[45:30]};
			w_q  <= s_tdata[57:46];
			h_q  <= s_tdata[69:58];
			dx_q <= s_tdata[82:70];
			dy_q <= s_tdata[95:83];
		end else if (st_q == StNext) begin
			if (tsize_q == 0) begin
				x_q <= sat($signed({3'd0, x_q}) + 20'(dx_q));
				y_q <= sat($signed({3'd0, y_q}) + 20'(dy_q));
			end else if (axis_q) begin
				y_q <= sat(mv);
			end else begin
				x_q <= sat(mv);
			end
		end else if (st_q == StLChk && solid_now) begin
			if (axis_q) y_q <= sat(snap);
			else x_q <= sat(snap);
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != StIdle) |-> !s_tready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !drsp.busy) else $error("divider restarted");
`endif

endmodule

/* bench/testbench.sv */
module testbench;

	// one input transaction, fields as packed into s_tdata (lowest first)
	typedef struct {
		logic        cmd;
		logic [5:0]  col;
		logic [5:0]  row;
		logic        solid;
		logic [15:0] left;
		logic [15:0] top;
		logic [11:0] wid;
		logic [11:0] hgt;
		logic [12:0] mx;
		logic [12:0] my;
	} item_t;

	bit sender_stall_ok = 1'b1;
	bit receiver_stall_ok = 1'b1;

	// collision predictor: tile map, registers, queue of expected positions
	class collision_scoreboard;
		bit          solid_map [64][64];
		int          tile_edge;
		int          map_cols;
		int          map_rows;
		int unsigned error_count;
		logic [31:0] expected_pos [$];

		function new();
			tile_edge   = 16;
			map_cols    = 64;
			map_rows    = 64;
			error_count = 0;
			foreach (solid_map[i, j]) solid_map[i][j] = 1'b0;
		endfunction

		task report(input string what);
			$display("mismatch: %s", what);
			error_count++;
		endtask

		function void set_reg(input logic [1:0] idx, input logic [6:0] val);
			case (idx)
				tmbcr_pkg::CfgTileSize: tile_edge = val;
				tmbcr_pkg::CfgMapCols:  map_cols = val;
				tmbcr_pkg::CfgMapRows:  map_rows = val;
				default: ;
			endcase
		endfunction

		function bit is_solid(input longint tx, input longint ty);
			longint c;
			longint r;
			c = map_cols < 64 ? map_cols : 64;
			r = map_rows < 64 ? map_rows : 64;
			if (tx >= c || ty >= r) return 1'b1;
			return solid_map[ty][tx];
		endfunction

		function longint last_idx(input longint p, input longint len, input longint span);
			if (p + len <= 0) return 0;
			return (p + len - 1) / span;
		endfunction

		function longint clamp16(input longint v);
			if (v < 0) return 0;
			if (v > 65535) return 65535;
			return v;
		endfunction

		function bit overlaps(input longint x, input longint y, input longint w,
				input longint h, input longint span);
			for (longint ty = y / span; ty <= last_idx(y, h, span); ty++)
				for (longint tx = x / span; tx <= last_idx(x, w, span); tx++)
					if (is_solid(tx, ty)) return 1'b1;
			return 1'b0;
		endfunction

		// note an accepted input transaction
		function void accept(input item_t it);
			longint x, y, w, h, dx, dy, span, lead;
			if (it.cmd == tmbcr_pkg::CmdWrite) begin
				solid_map[it.row][it.col] = it.solid;
				return;
			end
			x = it.left; y = it.top; w = it.wid; h = it.hgt;
			dx = $signed(it.mx); dy = $signed(it.my);
			span = longint'(tile_edge) << tmbcr_pkg::FracBits;
			// X phase
			x = clamp16(x + dx);
			if (span != 0 && dx != 0 && overlaps(x, y, w, h, span)) begin
				lead = dx > 0 ? last_idx(x, w, span) : x / span;
				for (longint k = y / span; k <= last_idx(y, h, span); k++)
					if (is_solid(lead, k)) begin
						x = dx > 0 ? clamp16(lead * span - w) : clamp16((lead + 1) * span);
						break;
					end
			end
			// Y phase, from the resolved X
			y = clamp16(y + dy);
			if (span != 0 && dy != 0 && overlaps(x, y, w, h, span)) begin
				lead = dy > 0 ? last_idx(y, h, span) : y / span;
				for (longint k = x / span; k <= last_idx(x, w, span); k++)
					if (is_solid(k, lead)) begin
						y = dy > 0 ? clamp16(lead * span - h) : clamp16((lead + 1) * span);
						break;
					end
			end
			expected_pos.push_back({y[15:0], x[15:0]});
		endfunction

		task check(input logic [31:0] got);
			logic [31:0] exp;
			if (expected_pos.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			exp = expected_pos.pop_front();
			if (got[15:0] !== exp[15:0])
				report($sformatf("new_left %h, expected %h", got[15:0], exp[15:0]));
			if (got[31:16] !== exp[31:16])
				report($sformatf("new_top %h, expected %h", got[31:16], exp[31:16]));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	collision_scoreboard board = new();
	int unsigned quiet_cycles = 0;

	tile_map_box_collision_resolve dut (.*);

	always #5 clk = ~clk;

	// receiver with random backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.check(m_tdata);
			m_tready <= !(receiver_stall_ok && $urandom_range(99) < 6);
		end
	end

	// watchdog: cycles with no transaction (clearing pass and full-map scans fit)
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 100000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_reg(idx, val);
		@(posedge clk);
	endtask

	// valid stays high after the handshake; the next send or drain sets it
	task automatic send(input item_t it);
		while (sender_stall_ok && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {it.my, it.mx, it.hgt, it.wid, it.top, it.left,
			it.solid, it.row, it.col, it.cmd};
		do @(posedge clk); while (!s_tready);
		board.accept(it);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.expected_pos.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic item_t tile_write(input int c, input int r, input bit s);
		item_t it;
		it = '{default: '0};
		it.cmd = tmbcr_pkg::CmdWrite; it.col = 6'(c); it.row = 6'(r); it.solid = s;
		return it;
	endfunction

	// moves kept mostly in or near the configured map, sometimes fully random
	function automatic item_t rand_move(input int span_px);
		item_t it;
		int extent;
		it = '{default: '0};
		it.cmd = tmbcr_pkg::CmdMove;
		it.col = 6'($urandom); it.row = 6'($urandom); it.solid = 1'($urandom);
		if ($urandom_range(9) == 0) begin
			it.left = 16'($urandom); it.top = 16'($urandom);
			it.wid = 12'($urandom); it.hgt = 12'($urandom);
			it.mx = 13'($urandom); it.my = 13'($urandom);
		end else begin
			extent = span_px * 12 * 16;
			if (extent > 65535 || extent == 0) extent = 65535;
			it.left = 16'($urandom_range(extent)); it.top = 16'($urandom_range(extent));
			it.wid = 12'($urandom_range(span_px * 16 * 2 + 1, 1));
			it.hgt = 12'($urandom_range(span_px * 16 * 2 + 1, 1));
			it.mx = 13'(int'($urandom_range(span_px * 16 + 8)) - (span_px * 8 + 4));
			it.my = 13'(int'($urandom_range(span_px * 16 + 8)) - (span_px * 8 + 4));
			if ($urandom_range(7) == 0) it.mx = '0;
			if ($urandom_range(7) == 0) it.my = '0;
		end
		return it;
	endfunction

	function automatic item_t move(input int l, input int t, input int w, input int h,
			input int dx, input int dy);
		item_t it;
		it = '{default: '0};
		it.cmd = tmbcr_pkg::CmdMove; it.left = 16'(l); it.top = 16'(t);
		it.wid = 12'(w); it.hgt = 12'(h);
		it.mx = 13'(dx); it.my = 13'(dy);
		return it;
	endfunction

	initial begin
		int sizes [6] = '{16, 1, 64, 0, 8, 127};
		int cols  [6] = '{64, 1, 10, 64, 0, 127};
		int rows  [6] = '{64, 1, 12, 64, 127, 0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: walls, extremes, zero moves, saturation
		send(tile_write(5, 5, 1));
		send(tile_write(63, 63, 1));
		send(tile_write(0, 0, 1));
		send(tile_write(0, 0, 0));
		send(move(70 * 16, 80 * 16, 160, 160, 200, 0));
		send(move(100 * 16, 80 * 16, 160, 160, -200, 0));
		send(move(80 * 16, 60 * 16, 160, 160, 0, 300));
		send(move(80 * 16, 100 * 16, 160, 160, 0, -300));
		send(move(0, 0, 1, 1, -4096, -4096));
		send(move(65535, 65535, 4095, 4095, 4095, 4095));
		send(move(1000, 1000, 4095, 1, 0, 0));
		send(move(16, 16, 16, 16, 4095, -1));
		send(move(50000, 300, 100, 100, -4096, 4095));
		drain();

		// pause with nothing outstanding is done by drain; phases over settings
		for (int p = 0; p < 6; p++) begin
			write_reg(tmbcr_pkg::CfgTileSize, 7'(sizes[p]));
			write_reg(tmbcr_pkg::CfgMapCols, 7'(cols[p]));
			write_reg(tmbcr_pkg::CfgMapRows, 7'(rows[p]));
			sender_stall_ok   = (p != 2);
			receiver_stall_ok = (p != 2);
			for (int i = 0; i < 340; i++) begin
				if ($urandom_range(2) == 0)
					send(tile_write($urandom, $urandom, 1'($urandom)));
				else
					send(rand_move(sizes[p] == 0 ? 16 : (sizes[p] > 64 ? 64 : sizes[p])));
			end
			drain();
		end

		if (board.error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

/* tile_map_box_collision_resolve.f */
rtl/core/tmbcr_pkg.sv
rtl/core/tmbcr_ram.sv
rtl/core/tmbcr_div.sv
rtl/core/tile_map_box_collision_resolve.sv
bench/testbench.sv
